// File: rtl/mcts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcts_pkg: shared types and constants of the timeout scheduler
// Field widths, the word layouts, the request codes, the controller states
// and the constants of the nanosecond and millisecond conversions.
// ----------------------------------------------------------------------------
package mcts_pkg;

  localparam int DATA_W    = 64;   // deadlines, times and delays
  localparam int MODE_W    = 2;
  localparam int CLIENT_W  = 3;
  localparam int NOTIFY_W  = 6;
  localparam int MS_W      = 32;

  localparam int S_TDATA_W = 136;  // client, relative_ns, now_us, zero fill
  localparam int M_TDATA_W = 104;  // time_ns, notify_mask, arm_valid, arm_ms, armed

  // Divide by 1e6 as a shift by 6 followed by a divide by 15625.
  localparam int DIV_SHIFT     = 6;
  localparam int DIV_ODD       = 15625;
  localparam int DIV_REM_W     = 14;
  localparam int DIV_STEPS     = 8;   // quotient bits per cycle
  localparam int DIV_CYCLES    = DATA_W / DIV_STEPS;
  localparam int DIV_CNT_W     = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_TIME   = 2'd0,
    MODE_SET    = 2'd1,
    MODE_EXPIRE = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_SET,
    S_SCAN,
    S_SUB,
    S_DIV,
    S_DONE
  } state_t;

  // Write side of the deadline memory (address travels separately).
  typedef struct packed {
    logic              en;
    logic [DATA_W-1:0] data;
  } ram_wr_t;

endpackage

// File: rtl/multi_client_timeout_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_client_timeout_scheduler: one one-shot timer shared by many clients
// Keeps an absolute nanosecond deadline per client in a small memory and
// decides when and for how long the one-shot timer is programmed.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_t*): one word per request. tuser carries the mode
//   (get time, set timeout, timer expiry); tdata carries the client, the
//   relative delay in ns and the sampled microsecond counter.
//   Output stream (m_t*): exactly one word per request, with the time in ns,
//   the clients notified, whether the one-shot is reprogrammed, its delay in
//   ms and whether it is armed afterwards.
//   The expiry scan reads one deadline per cycle through the memory's single
//   read port. A set timeout or an expiry that rearms the timer also runs
//   the millisecond divider before its result word is ready.
//   One request is in flight at a time; the next is taken as soon as the
//   previous result sits in the output register, even while the receiver
//   stalls it. A stalled result holds its word until it is taken.
//   Reset clears the armed state, the output valid bit and the valid bits of
//   the deadline memory, so every slot reads empty right after reset.
// ----------------------------------------------------------------------------
module multi_client_timeout_scheduler
  import mcts_pkg::*;
#(
  parameter int CLIENTS = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // client[2:0], relative_ns[66:3], now_us[130:67]
  input  logic [MODE_W-1:0]    s_tuser,  // mode[1:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata   // time_ns[63:0], notify_mask[69:64],
                                         // arm_valid[70], arm_ms[102:71], armed[103]
);

  localparam int IW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;

  state_t state, state_next;

  // Latched request
  logic [MODE_W-1:0]   mode_q;
  logic [CLIENT_W-1:0] client_q;
  logic [DATA_W-1:0]   rel_q;
  logic [DATA_W-1:0]   now_us_q;
  logic [DATA_W-1:0]   now_ns;

  // Timer state
  logic                timer_armed;
  logic [IW-1:0]       armed_client;
  logic [DATA_W-1:0]   armed_deadline;

  // Result under construction
  logic [NOTIFY_W-1:0] notify;
  logic                arm_valid_q;
  logic [MS_W-1:0]     arm_ms_q;

  // Scan bookkeeping
  logic [IW:0]         rd_cnt;
  logic                chk_valid;
  logic [IW-1:0]       chk_idx;
  logic                clr_active;
  logic [DATA_W-1:0]   best;
  logic [IW-1:0]       best_c;
  logic                found;

  // Output register
  logic                   out_valid;
  logic [M_TDATA_W-1:0]   out_data;

  // Memory and divider hookup
  logic                rd_en;
  logic [IW-1:0]       rd_addr;
  logic [DATA_W-1:0]   rd_data;
  ram_wr_t             wr;
  logic [IW-1:0]       wr_addr;
  logic                div_start;
  logic [DATA_W-1:0]   div_dividend;
  logic                div_done;
  logic [MS_W-1:0]     div_quotient;

  // Combinational helpers
  logic                in_accept;
  logic                out_load;
  logic                client_ok;
  logic [DATA_W-1:0]   abs_dl;
  logic                set_arm;
  logic                clr_hit;
  logic [DATA_W-1:0]   d_eff;
  logic                overdue;
  logic                cand;
  logic                scan_last;
  logic [NOTIFY_W-1:0] chk_bit;
  logic [NOTIFY_W-1:0] armed_bit;

  assign in_accept = s_tvalid && s_tready;
  assign s_tready  = (state == S_IDLE);
  assign out_load  = (state == S_DONE) && (!out_valid || m_tready);

  assign client_ok = 32'(client_q) < 32'(CLIENTS);
  assign abs_dl    = now_ns + rel_q;
  assign set_arm   = !timer_armed || (abs_dl < armed_deadline);

  // Clients past the notify field width get no bit: the shift drops them.
  assign chk_bit   = NOTIFY_W'(1) << chk_idx;
  assign armed_bit = NOTIFY_W'(1) << armed_client;

  // Fold the clearing of the armed client into the scan.
  assign clr_hit   = clr_active && (chk_idx == armed_client);
  assign d_eff     = clr_hit ? '0 : rd_data;
  assign overdue   = (d_eff != '0) && (d_eff <= now_ns);
  assign cand      = (d_eff != '0) && !overdue && (d_eff < best);
  assign scan_last = chk_valid && (chk_idx == IW'(CLIENTS - 1));

  // Next state and strobes
  always_comb begin
    state_next   = state;
    rd_en        = 1'b0;
    rd_addr      = rd_cnt[IW-1:0];
    wr.en        = 1'b0;
    wr.data      = '0;
    wr_addr      = chk_idx;
    div_start    = 1'b0;
    div_dividend = best - now_ns;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        unique case (mode_q)
          MODE_SET:    state_next = client_ok ? S_SET : S_DONE;
          MODE_EXPIRE: state_next = S_SCAN;
          default:     state_next = S_DONE;
        endcase
      end
      S_SET: begin
        wr.en        = 1'b1;
        wr.data      = abs_dl;
        wr_addr      = IW'(client_q);
        div_dividend = rel_q;
        div_start    = set_arm;
        state_next   = set_arm ? S_DIV : S_DONE;
      end
      S_SCAN: begin
        rd_en = rd_cnt < (IW+1)'(CLIENTS);
        if (chk_valid && (overdue || clr_hit)) begin
          wr.en = 1'b1;
        end
        if (scan_last) begin
          state_next = (found || cand) ? S_SUB : S_DONE;
        end
      end
      S_SUB: begin
        div_start  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_armed  <= 1'b0;
      armed_client <= '0;
      out_valid    <= 1'b0;
      chk_valid    <= 1'b0;
      rd_cnt       <= '0;
      clr_active   <= 1'b0;
      found        <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end

      chk_valid <= rd_en;

      if (state == S_CALC) begin
        rd_cnt <= '0;
        found  <= 1'b0;
        if (mode_q == MODE_EXPIRE) begin
          // Drop the armed timer; its client is cleared during the scan.
          clr_active  <= timer_armed;
          timer_armed <= 1'b0;
        end else begin
          clr_active <= 1'b0;
        end
      end

      if (rd_en) begin
        rd_cnt <= rd_cnt + 1'b1;
      end

      if (state == S_SCAN && chk_valid && cand) begin
        found <= 1'b1;
      end

      if (state == S_SET && set_arm) begin
        timer_armed  <= 1'b1;
        armed_client <= IW'(client_q);
      end

      if (state == S_SCAN && scan_last && (found || cand)) begin
        timer_armed  <= 1'b1;
        armed_client <= cand ? chk_idx : best_c;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (in_accept) begin
      mode_q      <= s_tuser;
      client_q    <= s_tdata[CLIENT_W-1:0];
      rel_q       <= s_tdata[CLIENT_W +: DATA_W];
      now_us_q    <= s_tdata[CLIENT_W+DATA_W +: DATA_W];
      notify      <= '0;
      arm_valid_q <= 1'b0;
      arm_ms_q    <= '0;
    end

    if (state == S_CALC) begin
      // now_us * 1000 = now_us * (1024 - 16 - 8), modulo 2^64
      now_ns <= (now_us_q << 10) - (now_us_q << 4) - (now_us_q << 3);
      best   <= '1;
      best_c <= '0;
      if (mode_q == MODE_EXPIRE && timer_armed) begin
        notify <= armed_bit;
      end
    end

    if (state == S_SET && set_arm) begin
      armed_deadline <= abs_dl;
      arm_valid_q    <= 1'b1;
    end

    if (state == S_SCAN && chk_valid) begin
      if (overdue) begin
        notify <= notify | chk_bit;
      end
      if (cand) begin
        best   <= d_eff;
        best_c <= chk_idx;
      end
    end

    if (rd_en) begin
      chk_idx <= rd_addr;
    end

    if (state == S_SUB) begin
      armed_deadline <= best;
      arm_valid_q    <= 1'b1;
    end

    if (state == S_DIV && div_done) begin
      arm_ms_q <= div_quotient;
    end

    if (out_load) begin
      out_data <= {timer_armed, arm_ms_q, arm_valid_q, notify, now_ns};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  mcts_deadline_ram #(
    .DEPTH  (CLIENTS),
    .ADDR_W (IW)
  ) u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr),
    .wr_addr (wr_addr)
  );

  mcts_ms_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .done     (div_done),
    .quotient (div_quotient)
  );

endmodule

// File: rtl/mcts_deadline_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcts_deadline_ram: deadline memory
// One write port and one registered read port. Entries never written since
// reset read as zero through a valid bit per entry.
// ----------------------------------------------------------------------------
module mcts_deadline_ram
  import mcts_pkg::*;
#(
  parameter int DEPTH  = 6,
  parameter int ADDR_W = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  ram_wr_t           wr,
  input  logic [ADDR_W-1:0] wr_addr
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld;
  logic [DATA_W-1:0] mem_q;
  logic              vld_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q <= vld[rd_addr];
      end
    end
  end

  assign rd_data = vld_q ? mem_q : '0;

endmodule

// File: rtl/mcts_ms_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcts_ms_div: nanoseconds to milliseconds
// Shift out the factor 64, then restoring division by 15625, eight quotient
// bits per cycle. Keeps the low 32 quotient bits.
// ----------------------------------------------------------------------------
module mcts_ms_div
  import mcts_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  output logic              done,
  output logic [MS_W-1:0]   quotient
);

  logic [DATA_W-1:0]    num, num_next;
  logic [DIV_REM_W-1:0] rem, rem_next;
  logic [MS_W-1:0]      quo, quo_next;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 run;

  always_comb begin
    logic [DIV_REM_W:0] t;
    num_next = num;
    rem_next = rem;
    quo_next = quo;
    for (int k = 0; k < DIV_STEPS; k++) begin
      t        = {rem_next, num_next[DATA_W-1]};
      num_next = {num_next[DATA_W-2:0], 1'b0};
      if (t >= (DIV_REM_W+1)'(DIV_ODD)) begin
        t        = t - (DIV_REM_W+1)'(DIV_ODD);
        quo_next = {quo_next[MS_W-2:0], 1'b1};
      end else begin
        quo_next = {quo_next[MS_W-2:0], 1'b0};
      end
      rem_next = t[DIV_REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend >> DIV_SHIFT;
      rem <= '0;
      quo <= '0;
    end else if (run) begin
      num <= num_next;
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = quo;

endmodule

// File: rtl/mcts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcts_checker: port-level checks of the timeout scheduler
// Watches the output stream for words that cannot come from a valid step.
// ----------------------------------------------------------------------------
module mcts_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [103:0] m_tdata
);

  // Hold a stalled word.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word changed");

  // Leave reset with an empty output register.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // A reprogrammed timer is an armed timer.
  a_arm_armed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[70] |-> m_tdata[103])
    else $error("arm_valid without armed");

  // No delay without reprogramming.
  a_ms_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[70] |-> m_tdata[102:71] == 32'd0)
    else $error("arm_ms set while arm_valid is low");

  // Time in ns is a multiple of 1000, so of 8.
  a_time_mult: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] == 3'd0)
    else $error("time_ns is not a multiple of 8");

endmodule

bind multi_client_timeout_scheduler mcts_checker u_mcts_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: tb/tb_multi_client_timeout_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_client_timeout_scheduler: self-checking bench of the timeout scheduler
// Drives request words with random gaps and stalls the result stream at
// random. A scoreboard keeps its own copy of the deadline table and of the
// armed one-shot. From each accepted request it predicts the result word and
// compares every field of each returned word with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_multi_client_timeout_scheduler
  import mcts_pkg::*;
;

  localparam int CLIENTS       = 6;
  localparam int RESET_CYCLES  = 12;
  localparam int RANDOM_ITEMS  = 1150;           // random requests after the directed part
  localparam int DRAIN_CYCLES  = 40;             // quiet time after the last result, to catch strays
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int PAD_W         = S_TDATA_W - CLIENT_W - 2 * DATA_W;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;  // reserved code, treated as get time
  localparam logic [DATA_W-1:0] NS_PER_US   = 64'd1000;
  localparam logic [DATA_W-1:0] NS_PER_MS   = 64'd1_000_000;
  localparam logic [DATA_W-1:0] ALL_ONES    = '1;

  // Result word, packed so that it overlays m_tdata bit for bit.
  typedef struct packed {
    logic                armed;
    logic [MS_W-1:0]     arm_ms;
    logic                arm_valid;
    logic [NOTIFY_W-1:0] notify;
    logic [DATA_W-1:0]   time_ns;
  } sched_word_t;

  // --------------------------------------------------------------------------
  // Scoreboard: deadline table, armed one-shot and the words still due
  // --------------------------------------------------------------------------
  class sched_scoreboard;
    logic [DATA_W-1:0]   deadline [CLIENTS];
    logic                timer_on;
    logic [CLIENT_W-1:0] timer_client;
    logic [DATA_W-1:0]   timer_deadline;
    sched_word_t         due_words [$];
    int unsigned         errors;
    int unsigned         checked;
    int unsigned         notifications;
    int unsigned         rearms;

    function new();
      foreach (deadline[i]) deadline[i] = '0;
      timer_on       = 1'b0;
      timer_client   = '0;
      timer_deadline = '0;
      errors         = 0;
      checked        = 0;
      notifications  = 0;
      rearms         = 0;
    endfunction

    // Update the table for one accepted request and queue the word it yields.
    function void note_request(logic [MODE_W-1:0] mode, logic [CLIENT_W-1:0] client,
                               logic [DATA_W-1:0] rel_ns, logic [DATA_W-1:0] now_us);
      sched_word_t         w;
      logic [DATA_W-1:0]   now_ns;
      logic [DATA_W-1:0]   abs_ns;
      logic [DATA_W-1:0]   best;
      logic [DATA_W-1:0]   quot;
      logic                found;
      logic [CLIENT_W-1:0] best_c;
      w         = '0;
      now_ns    = now_us * NS_PER_US;
      w.time_ns = now_ns;
      if (mode == MODE_SET && client < CLIENTS) begin
        abs_ns = now_ns + rel_ns;
        deadline[client] = abs_ns;
        if (!timer_on || abs_ns < timer_deadline) begin
          quot           = rel_ns / NS_PER_MS;
          w.arm_valid    = 1'b1;
          w.arm_ms       = quot[MS_W-1:0];
          timer_on       = 1'b1;
          timer_deadline = abs_ns;
          timer_client   = client;
        end
      end else if (mode == MODE_EXPIRE) begin
        // The armed client fires first, whatever its slot now holds.
        if (timer_on) begin
          timer_on = 1'b0;
          deadline[timer_client] = '0;
          w.notify[timer_client] = 1'b1;
        end
        // Fire every overdue slot; keep the lowest client of the earliest rest.
        best   = ALL_ONES;
        found  = 1'b0;
        best_c = '0;
        for (int i = 0; i < CLIENTS; i++) begin
          if (deadline[i] != 0 && deadline[i] <= now_ns) begin
            deadline[i] = '0;
            w.notify[i] = 1'b1;
          end else if (deadline[i] != 0 && deadline[i] < best) begin
            best   = deadline[i];
            best_c = CLIENT_W'(i);
            found  = 1'b1;
          end
        end
        if (found) begin
          quot           = (best - now_ns) / NS_PER_MS;
          w.arm_valid    = 1'b1;
          w.arm_ms       = quot[MS_W-1:0];
          timer_on       = 1'b1;
          timer_deadline = best;
          timer_client   = best_c;
        end
      end
      w.armed = timer_on;
      notifications += $countones(w.notify);
      if (w.arm_valid) rearms++;
      due_words.push_back(w);
    endfunction

    task report(string field, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      errors++;
      $display("word %0d: %s is %h, expected %h", checked, field, got, want);
    endtask

    task check_result(sched_word_t got);
      sched_word_t want;
      checked++;
      if (due_words.size() == 0) begin
        report("unexpected word, time_ns", got.time_ns, '0);
        return;
      end
      want = due_words.pop_front();
      if (got.time_ns !== want.time_ns)     report("time_ns", got.time_ns, want.time_ns);
      if (got.notify !== want.notify)       report("notify_mask", 64'(got.notify), 64'(want.notify));
      if (got.arm_valid !== want.arm_valid) report("arm_valid", 64'(got.arm_valid),
                                                   64'(want.arm_valid));
      if (got.arm_ms !== want.arm_ms)       report("arm_ms", 64'(got.arm_ms), 64'(want.arm_ms));
      if (got.armed !== want.armed)         report("armed", 64'(got.armed), 64'(want.armed));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block
  // --------------------------------------------------------------------------
  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;  // client, relative_ns, now_us, zero fill
  logic [MODE_W-1:0]    s_tuser  = '0;  // mode
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;        // time_ns, notify_mask, arm_valid, arm_ms, armed

  sched_scoreboard sb;
  int unsigned     cycle_count = 0;
  int unsigned     items_sent  = 0;
  bit              tx_calm     = 1'b0;  // sender runs back to back while set
  bit              rx_calm     = 1'b0;  // receiver starts no new stall while set
  int              rx_hold     = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  multi_client_timeout_scheduler #(
    .CLIENTS(CLIENTS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // --------------------------------------------------------------------------
  // Result side: check each accepted word, then pick the next ready value.
  // Most cycles take the word; a few stall briefly and a rare one stalls long.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : rx_side
    int pick;
    if (!rst && m_tvalid && m_tready) sb.check_result(sched_word_t'(m_tdata));
    if ($urandom_range(0, 199) == 0) rx_calm <= !rx_calm;
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else if (rx_calm) begin
      m_tready <= 1'b1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        rx_hold  <= (pick < 96) ? $urandom_range(0, 2) : $urandom_range(15, 60);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Idle cycles before the next word: mostly none, some short, a few long.
  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (tx_calm || pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Timeout delay in ns: mostly whole milliseconds plus a fraction.
  function automatic logic [DATA_W-1:0] pick_delay();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return 64'($urandom_range(0, 999_999));
    if (pick < 80) return 64'($urandom_range(1, 20_000)) * NS_PER_MS
                          + 64'($urandom_range(0, 999_999));
    if (pick < 95) return 64'($urandom_range(1, 100_000)) * 64'd100_000_000;
    return {$urandom, $urandom};
  endfunction

  // Present one word, hold it until the handshake, then let the scoreboard
  // see it. Leaves s_tvalid high so back-to-back words need no extra edge.
  task automatic send_word(input logic [MODE_W-1:0] mode, input logic [CLIENT_W-1:0] client,
                           input logic [DATA_W-1:0] rel_ns, input logic [DATA_W-1:0] now_us);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {{PAD_W{1'b0}}, now_us, rel_ns, client};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(mode, client, rel_ns, now_us);
    items_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stim
    logic [DATA_W-1:0]   clock_us;
    logic [DATA_W-1:0]   now_ns;
    logic [DATA_W-1:0]   rel;
    logic [DATA_W-1:0]   target;
    logic [CLIENT_W-1:0] client;
    logic [MODE_W-1:0]   mode;
    int                  pick;
    int                  effective;
    int                  directed;

    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Times below are in microseconds, delays in ns.
    send_word(MODE_TIME, 3'd0, '0, '0);                      // zero time
    send_word(MODE_TIME, 3'd5, ALL_ONES, ALL_ONES);          // ns product wraps
    send_word(MODE_UNUSED, 3'd2, 64'd5_000_000, 64'd77);     // reserved code
    send_word(MODE_EXPIRE, 3'd0, '0, 64'd100);               // expiry with nothing armed
    send_word(MODE_SET, 3'd7, 64'd5_000_000, 64'd100);       // client out of range
    send_word(MODE_SET, 3'd6, 64'd5_000_000, 64'd100);       // first client past the end
    send_word(MODE_SET, 3'd0, '0, '0);                       // deadline sums to zero, still armed
    send_word(MODE_EXPIRE, 3'd0, '0, '0);                    // fires client 0 from an empty slot
    send_word(MODE_SET, 3'd1, 64'd3_000_000, 64'd1000);      // arms at 4 ms
    send_word(MODE_SET, 3'd2, 64'd3_000_000, 64'd1000);      // same deadline, no rearm
    send_word(MODE_SET, 3'd3, 64'd3_000_000, 64'd1000);      // three-way tie
    send_word(MODE_EXPIRE, 3'd0, '0, 64'd1500);              // fires 1, tie goes to client 2
    send_word(MODE_SET, 3'd2, 64'd50_000_000, 64'd1500);     // armed client moved later
    send_word(MODE_EXPIRE, 3'd0, '0, 64'd2000);              // fires 2 anyway, arms 3
    send_word(MODE_SET, 3'd4, ALL_ONES, 64'd3000);           // sum wraps below armed, ms truncated
    send_word(MODE_SET, 3'd5, ALL_ONES - 64'd3_000_000, 64'd3000);  // deadline at the top value
    send_word(MODE_EXPIRE, 3'd0, '0, 64'd5000);              // fires 4 and overdue 3; top never armed
    send_word(MODE_EXPIRE, 3'd0, '0, 64'd6000);              // idle expiry with a slot still held
    send_word(MODE_SET, 3'd0, 64'd1_000_000, 64'd7000);
    send_word(MODE_SET, 3'd1, 64'd2_000_000, 64'd7000);
    send_word(MODE_SET, 3'd3, 64'd9_000_000_000, 64'd7000);
    send_word(MODE_EXPIRE, 3'd0, '0, 64'd20_000);            // fires 0 and overdue 1, arms 3
    send_word(MODE_SET, 3'd2, 64'd4_000_000, 64'd20_000);
    send_word(MODE_EXPIRE, 3'd0, '0, ALL_ONES);              // everything but the top slot overdue
    directed = items_sent;

    // Random part: mostly time moving forward with sets and expiries near the
    // armed deadline, the rest noise. Count the words that touch the state.
    clock_us  = 64'($urandom_range(0, 1_000_000));
    effective = 0;
    while (items_sent < directed + RANDOM_ITEMS) begin
      if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
      if (clock_us > (64'd1 << 48)) clock_us = 64'($urandom_range(0, 1000));
      now_ns = clock_us * NS_PER_US;
      pick   = $urandom_range(0, 99);
      mode   = MODE_SET;
      client = CLIENT_W'($urandom_range(0, CLIENTS - 1));
      rel    = pick_delay();
      if (pick < 35) begin
        clock_us = clock_us + $urandom_range(0, 2000);
      end else if (pick < 45) begin
        // Tie with the armed deadline, or move the armed client later.
        if (sb.timer_on && sb.timer_deadline > now_ns) begin
          rel = sb.timer_deadline - now_ns;
          if ($urandom_range(0, 1) == 1) begin
            client = sb.timer_client;
            rel    = rel + 64'($urandom_range(1, 5000)) * NS_PER_MS;
          end
        end
      end else if (pick < 70) begin
        // Expiry close to the armed deadline: a little early, just after or later.
        mode = MODE_EXPIRE;
        if (sb.timer_on && sb.timer_deadline[DATA_W-1:DATA_W-4] == 0) begin
          target = sb.timer_deadline / NS_PER_US;
          case ($urandom_range(0, 9))
            0, 1:                target = (target != 0) ? target - 1 : target;
            2, 3, 4, 5, 6, 7:    target = target + 1;
            default:             target = target + $urandom_range(0, 5000);
          endcase
          if (target > clock_us) clock_us = target;
        end else begin
          clock_us = clock_us + $urandom_range(0, 5000);
        end
      end else if (pick < 78) begin
        // Late expiry: many slots overdue at once.
        mode     = MODE_EXPIRE;
        clock_us = clock_us + $urandom_range(0, 30_000_000);
      end else if (pick < 86) begin
        mode     = MODE_TIME;
        clock_us = clock_us + $urandom_range(0, 500);
      end
      if (mode == MODE_EXPIRE) client = CLIENT_W'($urandom_range(0, 7));
      if (pick >= 86) begin
        // Noise: any code, any client, any delay and any time.
        mode   = MODE_W'($urandom_range(0, 3));
        client = CLIENT_W'($urandom_range(0, 7));
        rel    = {$urandom, $urandom};
        send_word(mode, client, rel, {$urandom, $urandom});
      end else begin
        send_word(mode, client, rel, clock_us);
      end
      if (mode == MODE_EXPIRE || (mode == MODE_SET && client < CLIENTS)) effective++;
    end
    s_tvalid <= 1'b0;

    // Drain: wait for the last word, then watch for strays.
    while (sb.due_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d directed, %0d random ones touching the state),",
             items_sent, directed, effective);
    $display("checked %0d result words in %0d cycles; %0d notifications, %0d rearms.",
             sb.checked, cycle_count, sb.notifications, sb.rearms);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("Cycle limit reached with %0d result words still due.", sb.due_words.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
